@@ rtl/lbi_pkg.sv @@
// shared types and constants for the yuy2 letterbox inserter
package lbi_pkg;

    localparam int WORD_W   = 32;
    localparam int REPEAT_W = 26;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int LW_REG_W   = 14;
    localparam int IL_REG_W   = 13;
    localparam int TOT_W      = 13;
    localparam int BIAS_W     = 14;
    localparam int LINES_W    = 13;

    localparam logic [WORD_W-1:0]   BORDER_WORD = 32'h8000_8000;
    localparam logic [REPEAT_W-1:0] REPEAT_MAX  = 26'h3FF_FFFF;

    typedef enum logic [2:0] {
        REG_LINE_WORDS  = 3'd0,
        REG_IMAGE_LINES = 3'd1,
        REG_LB_TOTAL    = 3'd2,
        REG_TOP_BIAS    = 3'd3,
        REG_TOPDOWN     = 3'd4
    } lbi_reg_t;

    typedef enum logic [1:0] {
        PH_TOP    = 2'd0,
        PH_WORD   = 2'd1,
        PH_BOTTOM = 2'd2
    } lbi_phase_t;

    // border run lengths handed from the register block to the sequencer
    typedef struct packed {
        logic                top_nz;
        logic                bot_nz;
        logic [REPEAT_W-1:0] top_run;
        logic [REPEAT_W-1:0] bot_run;
    } lbi_runs_t;

    // frame position of the item about to enter the sequencer
    typedef struct packed {
        logic first;
        logic last;
    } lbi_pos_t;

endpackage

@@ rtl/lbi_in_if.sv @@
// input channel: one packed yuy2 word per beat
interface lbi_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

@@ rtl/lbi_out_if.sv @@
// output channel: one result run per beat
interface lbi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [25:0] repeat_count;
    logic        is_border;
    logic        last_of_run;

    modport source (output valid, output data_word, output repeat_count,
                    output is_border, output last_of_run, input ready);
    modport sink   (input valid, input data_word, input repeat_count,
                    input is_border, input last_of_run, output ready);
endinterface

@@ rtl/yuy2_letterbox_inserter_unit.sv @@
// top level of the yuy2 letterbox inserter
//
// pixels carries one packed yuy2 word per beat, row-major, one frame after
// the next. results carries one run per beat: a passed source word with a
// repeat count of one, or a black border run of 0x80008000 whose repeat
// count is border lines times words per line. the first word of a frame
// is preceded by the top run, the last word is followed by the bottom run,
// and last_of_run marks the final beat caused by an input word.
// an accepted word passes through the input register and then the
// result register before it is offered on results. throughput: one
// word per cycle while results is ready; the first and last word of a
// frame each take one extra output beat when their border is nonzero,
// set by the single result register that emits one run per beat.
// a register write reaches the registered border split and clamped
// geometry, and from these the run length registers.
// reset clears the frame position and the pipeline and loads the register
// defaults. a stalled receiver holds the result steady; one more word is
// taken into the input register, then pixels.ready drops.
module yuy2_letterbox_inserter_unit #(
    parameter int MAX_LINE_WORDS = 8192,
    parameter int MAX_LINES      = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lbi_in_if.sink                        pixels,
    lbi_out_if.source                     results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbi_pkg::ADDR_W-1:0]    paddr,
    input  logic [lbi_pkg::DATA_W-1:0]    pwdata,
    output logic [lbi_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int WIL_W = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
    localparam int LI_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    logic [WIL_W-1:0]            lw_m1;
    logic [LI_W-1:0]             il_m1;
    lbi_pkg::lbi_runs_t          runs;
    lbi_pkg::lbi_pos_t           pos_flags;
    logic                        take;
    logic                        in_valid_reg;
    logic [lbi_pkg::WORD_W-1:0]  in_word_reg;

    assign pready       = 1'b1;
    assign pixels.ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (pixels.ready)
            in_valid_reg <= pixels.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixels.valid && pixels.ready)
            in_word_reg <= pixels.pixel_word;
    end

    lbi_cfg #(
        .MAX_LINE_WORDS (MAX_LINE_WORDS),
        .MAX_LINES      (MAX_LINES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .lw_m1   (lw_m1),
        .il_m1   (il_m1),
        .runs    (runs)
    );

    lbi_pos #(
        .MAX_LINE_WORDS (MAX_LINE_WORDS),
        .MAX_LINES      (MAX_LINES)
    ) u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (take),
        .lw_m1 (lw_m1),
        .il_m1 (il_m1),
        .flags (pos_flags)
    );

    lbi_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_word  (in_word_reg),
        .flags      (pos_flags),
        .runs       (runs),
        .take       (take),
        .results    (results)
    );

    // a source word beat always has a repeat count of one
    a_word_single: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.is_border) |-> (results.repeat_count == 26'd1))
        else $error("source word beat with repeat count other than one");

    // a top run beat is always followed by its source word
    a_top_then_word: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.is_border && !results.last_of_run)
        |=> (results.valid && !results.is_border))
        else $error("top border run not followed by source word");

    // the frame position wraps to the start after the last word
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pos_flags.last) |=> pos_flags.first)
        else $error("frame position did not wrap after last word");

endmodule

@@ rtl/lbi_cfg.sv @@
// register block with border split and run length precompute
module lbi_cfg #(
    parameter int MAX_LINE_WORDS = 8192,
    parameter int MAX_LINES      = 4096,
    localparam int WIL_W = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1,
    localparam int LI_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbi_pkg::ADDR_W-1:0]    paddr,
    input  logic [lbi_pkg::DATA_W-1:0]    pwdata,
    output logic [lbi_pkg::DATA_W-1:0]    prdata,
    output logic [WIL_W-1:0]              lw_m1,
    output logic [LI_W-1:0]               il_m1,
    output lbi_pkg::lbi_runs_t            runs
);

    logic [lbi_pkg::LW_REG_W-1:0] line_words_reg;
    logic [lbi_pkg::IL_REG_W-1:0] image_lines_reg;
    logic [lbi_pkg::TOT_W-1:0]    total_reg;
    logic [lbi_pkg::BIAS_W-1:0]   bias_reg;
    logic                         topdown_reg;

    lbi_pkg::lbi_reg_t reg_idx;
    logic              wr_en;

    assign reg_idx = lbi_pkg::lbi_reg_t'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_words_reg  <= 14'd360;
            image_lines_reg <= 13'd480;
            total_reg       <= '0;
            bias_reg        <= '0;
            topdown_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lbi_pkg::REG_LINE_WORDS:  line_words_reg  <= pwdata[lbi_pkg::LW_REG_W-1:0];
                lbi_pkg::REG_IMAGE_LINES: image_lines_reg <= pwdata[lbi_pkg::IL_REG_W-1:0];
                lbi_pkg::REG_LB_TOTAL:    total_reg       <= pwdata[lbi_pkg::TOT_W-1:0];
                lbi_pkg::REG_TOP_BIAS:    bias_reg        <= pwdata[lbi_pkg::BIAS_W-1:0];
                lbi_pkg::REG_TOPDOWN:     topdown_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lbi_pkg::REG_LINE_WORDS:  prdata = 32'(line_words_reg);
            lbi_pkg::REG_IMAGE_LINES: prdata = 32'(image_lines_reg);
            lbi_pkg::REG_LB_TOTAL:    prdata = 32'(total_reg);
            lbi_pkg::REG_TOP_BIAS:    prdata = 32'(bias_reg);
            lbi_pkg::REG_TOPDOWN:     prdata = 32'(topdown_reg);
            default:                  prdata = '0;
        endcase
    end

    // geometry clamp: zero acts as one, oversize acts as the maximum
    logic [WIL_W-1:0] lw_m1_next;
    logic [LI_W-1:0]  il_m1_next;

    always_comb
    begin
        if (line_words_reg == '0)
            lw_m1_next = '0;
        else if (32'(line_words_reg) > MAX_LINE_WORDS)
            lw_m1_next = WIL_W'(MAX_LINE_WORDS - 1);
        else
            lw_m1_next = WIL_W'(line_words_reg - 14'd1);

        if (image_lines_reg == '0)
            il_m1_next = '0;
        else if (32'(image_lines_reg) > MAX_LINES)
            il_m1_next = LI_W'(MAX_LINES - 1);
        else
            il_m1_next = LI_W'(image_lines_reg - 13'd1);
    end

    // border split: bias clamped to +/- total, bottom = (total - bias) / 2
    logic signed [14:0]                tot_s;
    logic signed [14:0]                bias_s;
    logic signed [14:0]                bias_c;
    logic signed [14:0]                diff_s;
    logic signed [14:0]                top_s;
    logic [lbi_pkg::LINES_W-1:0]       split_bot;
    logic [lbi_pkg::LINES_W-1:0]       split_top;
    logic [lbi_pkg::LINES_W-1:0]       top_lines_next;
    logic [lbi_pkg::LINES_W-1:0]       bot_lines_next;

    always_comb
    begin
        tot_s  = signed'({2'b00, total_reg});
        bias_s = signed'({bias_reg[lbi_pkg::BIAS_W-1], bias_reg});
        if (bias_s > tot_s)
            bias_c = tot_s;
        else if (bias_s < -tot_s)
            bias_c = -tot_s;
        else
            bias_c = bias_s;
        diff_s    = tot_s - bias_c;
        split_bot = diff_s[13:1];
        top_s     = signed'({2'b00, split_bot}) + bias_c;
        split_top = top_s[lbi_pkg::LINES_W-1:0];
        if (topdown_reg)
        begin
            top_lines_next = split_bot;
            bot_lines_next = split_top;
        end
        else
        begin
            top_lines_next = split_top;
            bot_lines_next = split_bot;
        end
    end

    logic [WIL_W-1:0]                 lw_m1_reg;
    logic [LI_W-1:0]                  il_m1_reg;
    logic [lbi_pkg::LINES_W-1:0]      top_lines_reg;
    logic [lbi_pkg::LINES_W-1:0]      bot_lines_reg;

    always_ff @(posedge clk)
    begin
        lw_m1_reg     <= lw_m1_next;
        il_m1_reg     <= il_m1_next;
        top_lines_reg <= top_lines_next;
        bot_lines_reg <= bot_lines_next;
    end

    // run length = lines * words per line, saturated
    logic [31:0]                      lw_full;
    logic [31:0]                      top_prod;
    logic [31:0]                      bot_prod;
    logic [lbi_pkg::REPEAT_W-1:0]     top_run_reg;
    logic [lbi_pkg::REPEAT_W-1:0]     bot_run_reg;

    assign lw_full  = 32'(lw_m1_reg) + 32'd1;
    assign top_prod = 32'(top_lines_reg) * lw_full;
    assign bot_prod = 32'(bot_lines_reg) * lw_full;

    always_ff @(posedge clk)
    begin
        top_run_reg <= (top_prod > 32'(lbi_pkg::REPEAT_MAX)) ? lbi_pkg::REPEAT_MAX
                                                             : top_prod[lbi_pkg::REPEAT_W-1:0];
        bot_run_reg <= (bot_prod > 32'(lbi_pkg::REPEAT_MAX)) ? lbi_pkg::REPEAT_MAX
                                                             : bot_prod[lbi_pkg::REPEAT_W-1:0];
    end

    assign lw_m1        = lw_m1_reg;
    assign il_m1        = il_m1_reg;
    assign runs.top_nz  = (top_lines_reg != '0);
    assign runs.bot_nz  = (bot_lines_reg != '0);
    assign runs.top_run = top_run_reg;
    assign runs.bot_run = bot_run_reg;

endmodule

@@ rtl/lbi_pos.sv @@
// word and line position tracker within the frame
module lbi_pos #(
    parameter int MAX_LINE_WORDS = 8192,
    parameter int MAX_LINES      = 4096,
    localparam int WIL_W = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1,
    localparam int LI_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [WIL_W-1:0]  lw_m1,
    input  logic [LI_W-1:0]   il_m1,
    output lbi_pkg::lbi_pos_t flags
);

    logic [WIL_W-1:0] word_in_line_reg;
    logic [LI_W-1:0]  line_index_reg;
    logic             end_line;

    // a position past a shrunk geometry counts as its end
    assign end_line    = (word_in_line_reg >= lw_m1);
    assign flags.first = (word_in_line_reg == '0) && (line_index_reg == '0);
    assign flags.last  = end_line && (line_index_reg >= il_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_in_line_reg <= '0;
            line_index_reg   <= '0;
        end
        else if (adv)
        begin
            if (flags.last)
            begin
                word_in_line_reg <= '0;
                line_index_reg   <= '0;
            end
            else if (end_line)
            begin
                word_in_line_reg <= '0;
                line_index_reg   <= line_index_reg + 1'b1;
            end
            else
            begin
                word_in_line_reg <= word_in_line_reg + 1'b1;
            end
        end
    end

endmodule

@@ rtl/lbi_seq.sv @@
// result register and run sequencer: top run, word, bottom run
module lbi_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic [lbi_pkg::WORD_W-1:0] item_word,
    input  lbi_pkg::lbi_pos_t          flags,
    input  lbi_pkg::lbi_runs_t         runs,
    output logic                       take,
    lbi_out_if.source                  results
);

    lbi_pkg::lbi_phase_t         phase_reg;
    lbi_pkg::lbi_phase_t         phase_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic                        bot_pend_reg;
    logic                        bot_pend_next;
    logic [lbi_pkg::WORD_W-1:0]  word_reg;
    logic                        final_beat;
    logic                        beat_done;

    always_comb
    begin
        case (phase_reg)
            lbi_pkg::PH_TOP:    final_beat = 1'b0;
            lbi_pkg::PH_WORD:   final_beat = !bot_pend_reg;
            lbi_pkg::PH_BOTTOM: final_beat = 1'b1;
            default:            final_beat = 1'b1;
        endcase
    end

    assign beat_done = busy_reg & results.ready;
    // next item enters as the last beat of the current one leaves
    assign take      = item_valid && (!busy_reg || (beat_done && final_beat));

    always_comb
    begin
        phase_next    = phase_reg;
        busy_next     = busy_reg;
        bot_pend_next = bot_pend_reg;
        if (take)
        begin
            busy_next     = 1'b1;
            phase_next    = (flags.first && runs.top_nz) ? lbi_pkg::PH_TOP : lbi_pkg::PH_WORD;
            bot_pend_next = flags.last && runs.bot_nz;
        end
        else if (beat_done)
        begin
            if (final_beat)
                busy_next = 1'b0;
            else
            begin
                case (phase_reg)
                    lbi_pkg::PH_TOP:  phase_next = lbi_pkg::PH_WORD;
                    lbi_pkg::PH_WORD: phase_next = lbi_pkg::PH_BOTTOM;
                    default:          phase_next = phase_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            phase_reg    <= lbi_pkg::PH_WORD;
            bot_pend_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            phase_reg    <= phase_next;
            bot_pend_reg <= bot_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            word_reg <= item_word;
    end

    always_comb
    begin
        results.valid       = busy_reg;
        results.last_of_run = final_beat;
        case (phase_reg)
            lbi_pkg::PH_TOP:
            begin
                results.data_word    = lbi_pkg::BORDER_WORD;
                results.repeat_count = runs.top_run;
                results.is_border    = 1'b1;
            end
            lbi_pkg::PH_BOTTOM:
            begin
                results.data_word    = lbi_pkg::BORDER_WORD;
                results.repeat_count = runs.bot_run;
                results.is_border    = 1'b1;
            end
            default:
            begin
                results.data_word    = word_reg;
                results.repeat_count = 26'd1;
                results.is_border    = 1'b0;
            end
        endcase
    end

endmodule
